FILE: hdl/mec_pkg.sv
// ---------------------------------------------------------------------------
// mec_pkg: shared types and constants for the mesh edge classifier
// Field widths, word structs between pipeline stages, register indexes and
// the signed multiply helpers used by the stage modules.
// ---------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int INDEX_BITS     = 20;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_BITS      = UNIT_FRAC_BITS + 2;
  localparam int COORD_BITS     = 24;
  localparam int FACE_BITS      = 3;

  // Exact widths of the intermediate products and sums
  localparam int PROD_AB_BITS = 2 * UNIT_BITS;
  localparam int DOT_BITS     = PROD_AB_BITS + 2;
  localparam int PROD_EA_BITS = COORD_BITS + UNIT_BITS;
  localparam int NRM_BITS     = PROD_EA_BITS + 1;
  localparam int PROD_NV_BITS = NRM_BITS + UNIT_BITS;
  localparam int DV_BITS      = PROD_NV_BITS + 2;

  localparam int CFG_DATA_BITS = UNIT_BITS;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [FACE_BITS-1:0] FACES_BOUNDARY = FACE_BITS'(1);
  localparam logic [FACE_BITS-1:0] FACES_PAIR     = FACE_BITS'(2);

  localparam logic [CFG_IDX_BITS-1:0] REG_CREASE_COSINE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_X        = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_Y        = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_Z        = CFG_IDX_BITS'(3);

  localparam logic signed [UNIT_BITS-1:0] VIEW_Z_RESET = UNIT_BITS'(16384);

  typedef struct packed {
    logic [FACE_BITS-1:0]         face_count;
    logic [INDEX_BITS-1:0]        start_index;
    logic [INDEX_BITS-1:0]        end_index;
    logic signed [UNIT_BITS-1:0]  plane_a_x;
    logic signed [UNIT_BITS-1:0]  plane_a_y;
    logic signed [UNIT_BITS-1:0]  plane_a_z;
    logic signed [UNIT_BITS-1:0]  plane_b_x;
    logic signed [UNIT_BITS-1:0]  plane_b_y;
    logic signed [UNIT_BITS-1:0]  plane_b_z;
    logic signed [COORD_BITS-1:0] edge_dx;
    logic signed [COORD_BITS-1:0] edge_dy;
    logic signed [COORD_BITS-1:0] edge_dz;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] out_start_index;
    logic [INDEX_BITS-1:0] out_end_index;
    logic                  is_boundary;
    logic                  is_crease;
    logic                  is_silhouette;
  } out_word_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] x;
    logic signed [UNIT_BITS-1:0] y;
    logic signed [UNIT_BITS-1:0] z;
  } view_t;

  typedef struct packed {
    logic boundary;
    logic pair;
    logic crease;
  } flags_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]              start_index;
    logic [INDEX_BITS-1:0]              end_index;
    flags_t                             flags;
    logic [2:0][PROD_AB_BITS-1:0]       ab;
    logic [2:0][PROD_EA_BITS-1:0]       n0_p;
    logic [2:0][PROD_EA_BITS-1:0]       n0_m;
    logic [2:0][PROD_EA_BITS-1:0]       n1_p;
    logic [2:0][PROD_EA_BITS-1:0]       n1_m;
  } s1_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]          start_index;
    logic [INDEX_BITS-1:0]          end_index;
    flags_t                         flags;
    logic [2:0][NRM_BITS-1:0]       n0;
    logic [2:0][NRM_BITS-1:0]       n1;
  } s2_word_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]          start_index;
    logic [INDEX_BITS-1:0]          end_index;
    flags_t                         flags;
    logic [2:0][PROD_NV_BITS-1:0]   nv0;
    logic [2:0][PROD_NV_BITS-1:0]   nv1;
  } s3_word_t;

  function automatic logic signed [PROD_AB_BITS-1:0] mul_uu(
    input logic signed [UNIT_BITS-1:0] p,
    input logic signed [UNIT_BITS-1:0] q
  );
    return PROD_AB_BITS'(p) * PROD_AB_BITS'(q);
  endfunction

  function automatic logic signed [PROD_EA_BITS-1:0] mul_cu(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [UNIT_BITS-1:0]  q
  );
    return PROD_EA_BITS'(p) * PROD_EA_BITS'(q);
  endfunction

  function automatic logic signed [PROD_NV_BITS-1:0] mul_nu(
    input logic signed [NRM_BITS-1:0]  p,
    input logic signed [UNIT_BITS-1:0] q
  );
    return PROD_NV_BITS'(p) * PROD_NV_BITS'(q);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mec_prod_stage.sv
// ---------------------------------------------------------------------------
// mec_prod_stage: first pipeline stage
// Forms all fifteen plane and cross products of one edge and decodes the
// face count.
// ---------------------------------------------------------------------------
`default_nettype none

module mec_prod_stage (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire mec_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output mec_pkg::s1_word_t        out_word
);
  import mec_pkg::*;

  logic     valid_r, valid_nxt;
  s1_word_t word_r, word_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    word_nxt = word_r;
    word_nxt.start_index    = in_word.start_index;
    word_nxt.end_index      = in_word.end_index;
    word_nxt.flags.boundary = (in_word.face_count == FACES_BOUNDARY);
    word_nxt.flags.pair     = (in_word.face_count == FACES_PAIR);
    word_nxt.flags.crease   = 1'b0;

    word_nxt.ab[0] = mul_uu(in_word.plane_a_x, in_word.plane_b_x);
    word_nxt.ab[1] = mul_uu(in_word.plane_a_y, in_word.plane_b_y);
    word_nxt.ab[2] = mul_uu(in_word.plane_a_z, in_word.plane_b_z);

    // n0 = e x a
    word_nxt.n0_p[0] = mul_cu(in_word.edge_dy, in_word.plane_a_z);
    word_nxt.n0_m[0] = mul_cu(in_word.edge_dz, in_word.plane_a_y);
    word_nxt.n0_p[1] = mul_cu(in_word.edge_dz, in_word.plane_a_x);
    word_nxt.n0_m[1] = mul_cu(in_word.edge_dx, in_word.plane_a_z);
    word_nxt.n0_p[2] = mul_cu(in_word.edge_dx, in_word.plane_a_y);
    word_nxt.n0_m[2] = mul_cu(in_word.edge_dy, in_word.plane_a_x);

    // n1 = b x e
    word_nxt.n1_p[0] = mul_cu(in_word.edge_dz, in_word.plane_b_y);
    word_nxt.n1_m[0] = mul_cu(in_word.edge_dy, in_word.plane_b_z);
    word_nxt.n1_p[1] = mul_cu(in_word.edge_dx, in_word.plane_b_z);
    word_nxt.n1_m[1] = mul_cu(in_word.edge_dz, in_word.plane_b_x);
    word_nxt.n1_p[2] = mul_cu(in_word.edge_dy, in_word.plane_b_x);
    word_nxt.n1_m[2] = mul_cu(in_word.edge_dx, in_word.plane_b_y);
  end

  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

FILE: hdl/mec_combine_stage.sv
// ---------------------------------------------------------------------------
// mec_combine_stage: second pipeline stage
// Subtracts the cross-product pairs into the two normals, sums the plane
// dot product and compares it with the crease threshold.
// ---------------------------------------------------------------------------
`default_nettype none

module mec_combine_stage (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire logic signed [mec_pkg::UNIT_BITS-1:0] crease_cosine,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire mec_pkg::s1_word_t   in_word,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output mec_pkg::s2_word_t        out_word
);
  import mec_pkg::*;

  logic                       valid_r, valid_nxt;
  s2_word_t                   word_r, word_nxt;
  logic signed [DOT_BITS-1:0] dot;
  logic signed [DOT_BITS-1:0] thr;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    dot = DOT_BITS'($signed(in_word.ab[0])) + DOT_BITS'($signed(in_word.ab[1]))
        + DOT_BITS'($signed(in_word.ab[2]));
    // threshold is minus the cosine, scaled to the product's Q4.28
    thr = (-DOT_BITS'(crease_cosine)) <<< UNIT_FRAC_BITS;

    word_nxt.start_index    = in_word.start_index;
    word_nxt.end_index      = in_word.end_index;
    word_nxt.flags          = in_word.flags;
    word_nxt.flags.crease   = in_word.flags.pair && (dot > thr);
    for (int k = 0; k < 3; k++) begin
      word_nxt.n0[k] = NRM_BITS'($signed(in_word.n0_p[k]))
                     - NRM_BITS'($signed(in_word.n0_m[k]));
      word_nxt.n1[k] = NRM_BITS'($signed(in_word.n1_p[k]))
                     - NRM_BITS'($signed(in_word.n1_m[k]));
    end
  end

  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

FILE: hdl/mec_view_stage.sv
// ---------------------------------------------------------------------------
// mec_view_stage: third pipeline stage
// Multiplies each normal component by the matching view component.
// ---------------------------------------------------------------------------
`default_nettype none

module mec_view_stage (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire mec_pkg::view_t      view,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire mec_pkg::s2_word_t   in_word,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output mec_pkg::s3_word_t        out_word
);
  import mec_pkg::*;

  logic     valid_r, valid_nxt;
  s3_word_t word_r, word_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    word_nxt.start_index = in_word.start_index;
    word_nxt.end_index   = in_word.end_index;
    word_nxt.flags       = in_word.flags;
    word_nxt.nv0[0] = mul_nu($signed(in_word.n0[0]), view.x);
    word_nxt.nv0[1] = mul_nu($signed(in_word.n0[1]), view.y);
    word_nxt.nv0[2] = mul_nu($signed(in_word.n0[2]), view.z);
    word_nxt.nv1[0] = mul_nu($signed(in_word.n1[0]), view.x);
    word_nxt.nv1[1] = mul_nu($signed(in_word.n1[1]), view.y);
    word_nxt.nv1[2] = mul_nu($signed(in_word.n1[2]), view.z);
  end

  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

FILE: hdl/mec_decide_stage.sv
// ---------------------------------------------------------------------------
// mec_decide_stage: fourth pipeline stage and output register
// Sums the two view dot products and sets the silhouette flag from their
// signs.
// ---------------------------------------------------------------------------
`default_nettype none

module mec_decide_stage (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire mec_pkg::s3_word_t   in_word,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output mec_pkg::out_word_t       out_word
);
  import mec_pkg::*;

  logic                      valid_r, valid_nxt;
  out_word_t                 word_r, word_nxt;
  logic signed [DV_BITS-1:0] d0;
  logic signed [DV_BITS-1:0] d1;
  logic                      opposite;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    d0 = DV_BITS'($signed(in_word.nv0[0])) + DV_BITS'($signed(in_word.nv0[1]))
       + DV_BITS'($signed(in_word.nv0[2]));
    d1 = DV_BITS'($signed(in_word.nv1[0])) + DV_BITS'($signed(in_word.nv1[1]))
       + DV_BITS'($signed(in_word.nv1[2]));
    // a zero product, or signs that differ, gives a non-positive sign product
    opposite = (d0 == '0) || (d1 == '0) || (d0[DV_BITS-1] != d1[DV_BITS-1]);

    word_nxt.out_start_index = in_word.start_index;
    word_nxt.out_end_index   = in_word.end_index;
    word_nxt.is_boundary     = in_word.flags.boundary;
    word_nxt.is_crease       = in_word.flags.crease;
    word_nxt.is_silhouette   = in_word.flags.pair && opposite;
  end

  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

FILE: hdl/mesh_edge_classifier.sv
// ---------------------------------------------------------------------------
// mesh_edge_classifier: boundary, crease and silhouette edge classifier
// Takes one mesh edge per word and returns its vertex indices with three
// classification flags, through a four-stage product pipeline.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ---------------------------
//  in_       input      in_valid / in_ready    in_word  (mec_pkg::in_word_t)
//  out_      output     out_valid / out_ready  out_word (mec_pkg::out_word_t)
//  cfg_      input      cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
//  One word enters per cycle unless a stall backs up to the input; each word's
//  result passes one register per stage: products, normals and plane dot,
//  view products, view dot and sign decision (the last is the output
//  register).
//  Reset (rst_n low, synchronous) empties every stage and loads the
//  configuration registers with their defaults: crease cosine 0, view (0,0,1).
//  A stalled result holds its own stage only; ready ripples back stage by
//  stage, so empty stages behind it keep filling.
// ---------------------------------------------------------------------------
`default_nettype none

module mesh_edge_classifier (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic                     in_ready,
  input  wire mec_pkg::in_word_t   in_word,
  output logic                     out_valid,
  input  wire                logic out_ready,
  output mec_pkg::out_word_t       out_word,
  input  wire                logic cfg_wr_en,
  input  wire logic [mec_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [mec_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import mec_pkg::*;

  // Configuration registers
  logic signed [UNIT_BITS-1:0] crease_r;
  view_t                       view_r;

  // Inter-stage handshakes and words
  logic     s1_valid, s1_ready;
  s1_word_t s1_word;
  logic     s2_valid, s2_ready;
  s2_word_t s2_word;
  logic     s3_valid, s3_ready;
  s3_word_t s3_word;

  // Register writes should land only while the pipeline is empty; the block
  // itself does not enforce this and takes them as they come.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crease_r <= '0;
      view_r.x <= '0;
      view_r.y <= '0;
      view_r.z <= VIEW_Z_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CREASE_COSINE: crease_r <= $signed(cfg_wdata);
        REG_VIEW_X:        view_r.x <= $signed(cfg_wdata);
        REG_VIEW_Y:        view_r.y <= $signed(cfg_wdata);
        REG_VIEW_Z:        view_r.z <= $signed(cfg_wdata);
        default: begin
          // drop writes to unknown registers
        end
      endcase
    end
  end

  // Stage 1: plane and cross products
  mec_prod_stage u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_word  (s1_word)
  );

  // Stage 2: normals, plane dot and crease test
  mec_combine_stage u_combine (
    .clk           (clk),
    .rst_n         (rst_n),
    .crease_cosine (crease_r),
    .in_valid      (s1_valid),
    .in_ready      (s1_ready),
    .in_word       (s1_word),
    .out_valid     (s2_valid),
    .out_ready     (s2_ready),
    .out_word      (s2_word)
  );

  // Stage 3: normal times view, per component
  mec_view_stage u_view (
    .clk       (clk),
    .rst_n     (rst_n),
    .view      (view_r),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_word   (s2_word),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_word  (s3_word)
  );

  // Stage 4: view dots, silhouette sign test, output register
  mec_decide_stage u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_word   (s3_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

FILE: hdl/mec_checker.sv
// ---------------------------------------------------------------------------
// mec_checker: port-level checks for the mesh edge classifier
// Watches the top-level ports over time; attached by the bind below.
// ---------------------------------------------------------------------------
`default_nettype none

module mec_checker (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  input  wire                logic in_ready,
  input  wire                logic out_valid,
  input  wire                logic out_ready,
  input  wire mec_pkg::out_word_t  out_word
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed or dropped while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Boundary excludes the two-face flags
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.is_boundary && (out_word.is_crease || out_word.is_silhouette)))
    else $error("boundary edge also flagged crease or silhouette");

  // With the sink ready, an accepted word is shown at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output in time");

endmodule

bind mesh_edge_classifier mec_checker u_mec_checker (.*);

`default_nettype wire
